>>> hw/rtl/pat_pkg.sv
// ----------------------------------------------------------------------------
// Pending ack table package
// Operation codes, default sizes and the types shared by the table modules.
// ----------------------------------------------------------------------------
package pat_pkg;

    localparam int ENTRIES_DEF    = 16;
    localparam int OWNER_BITS_DEF = 8;

    localparam int OP_W      = 2;
    localparam int PID_W     = 16;
    localparam int OWNER_IO_W = 8;

    localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK = 2'd2;

    // store access for one cycle
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_store_cmd;

    typedef struct packed {
        logic                  status;
        logic [OWNER_IO_W-1:0] found_owner;
    } t_result;

endpackage

>>> hw/rtl/pat_if.sv
// ----------------------------------------------------------------------------
// Pending ack table channels
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pat_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] packet_id;
    logic [7:0]  owner_id;

    modport source (output valid, output operation, output packet_id, output owner_id,
                    input ready);
    modport sink   (input valid, input operation, input packet_id, input owner_id,
                    output ready);
endinterface

interface pat_out_if;
    logic       valid;
    logic       ready;
    logic       status;
    logic [7:0] found_owner;

    modport source (output valid, output status, output found_owner, input ready);
    modport sink   (input valid, input status, input found_owner, output ready);
endinterface

>>> hw/rtl/pending_ack_table_top.sv
// ----------------------------------------------------------------------------
// Pending ack table top level
// Table of outstanding acknowledgements with add, find-and-remove and
// mark-stale operations, one result per request.
// ----------------------------------------------------------------------------
// One request is taken at a time and the entries are scanned in order, one per
// cycle, through the single read port of the entry memory. An unused operation
// code goes straight to the result; a scan ends at the first hit or at the last
// entry. The result sits in an output register, so a new request is taken
// while the previous result still waits on the output channel. No clearing
// pass follows reset: every entry has a valid bit that reset clears.
module pending_ack_table_top #(
    parameter int ENTRIES    = pat_pkg::ENTRIES_DEF,
    parameter int OWNER_BITS = pat_pkg::OWNER_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pat_in_if.sink     i_in,
    pat_out_if.source  o_out
);
    import pat_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    t_store_cmd            cmd;
    logic [IW-1:0]         raddr;
    logic [IW-1:0]         waddr;
    logic [OWNER_BITS-1:0] wr_owner;
    logic [PID_W-1:0]      wr_pid;
    logic                  wr_stale;
    logic [OWNER_BITS-1:0] rd_owner;
    logic [PID_W-1:0]      rd_pid;
    logic                  rd_stale;

    logic                  res_valid;
    logic                  res_ready;
    t_result               res;

    logic                  r_ovalid;
    t_result               r_ores;

    pat_seq #(
        .ENTRIES    (ENTRIES),
        .OWNER_BITS (OWNER_BITS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_operation (i_in.operation),
        .i_packet_id (i_in.packet_id),
        .i_owner_id  (i_in.owner_id),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_cmd       (cmd),
        .o_raddr     (raddr),
        .o_waddr     (waddr),
        .o_wr_owner  (wr_owner),
        .o_wr_pid    (wr_pid),
        .o_wr_stale  (wr_stale),
        .i_rd_owner  (rd_owner),
        .i_rd_pid    (rd_pid),
        .i_rd_stale  (rd_stale)
    );

    pat_store #(
        .ENTRIES    (ENTRIES),
        .OWNER_BITS (OWNER_BITS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_raddr    (raddr),
        .i_waddr    (waddr),
        .i_wr_owner (wr_owner),
        .i_wr_pid   (wr_pid),
        .i_wr_stale (wr_stale),
        .o_rd_owner (rd_owner),
        .o_rd_pid   (rd_pid),
        .o_rd_stale (rd_stale)
    );

    // output register: load when empty or when its transfer completes
    assign res_ready = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_ores <= res;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.status      = r_ores.status;
    assign o_out.found_owner = r_ores.found_owner;

endmodule

>>> hw/rtl/pat_store.sv
// ----------------------------------------------------------------------------
// Pending ack table entry store
// Entry memory with one registered read port, one write port and per-entry
// valid bits; an entry that is not valid reads as all zero.
// ----------------------------------------------------------------------------
module pat_store #(
    parameter int ENTRIES    = pat_pkg::ENTRIES_DEF,
    parameter int OWNER_BITS = pat_pkg::OWNER_BITS_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pat_pkg::t_store_cmd    i_cmd,
    input  logic [IW-1:0]          i_raddr,
    input  logic [IW-1:0]          i_waddr,
    input  logic [OWNER_BITS-1:0]  i_wr_owner,
    input  logic [pat_pkg::PID_W-1:0] i_wr_pid,
    input  logic                   i_wr_stale,
    output logic [OWNER_BITS-1:0]  o_rd_owner,
    output logic [pat_pkg::PID_W-1:0] o_rd_pid,
    output logic                   o_rd_stale
);
    import pat_pkg::*;

    logic [OWNER_BITS-1:0] mem_owner [ENTRIES];
    logic [PID_W-1:0]      mem_pid   [ENTRIES];
    logic                  mem_stale [ENTRIES];

    logic [ENTRIES-1:0]    r_valid;
    logic                  r_rv;
    logic [OWNER_BITS-1:0] r_rd_owner;
    logic [PID_W-1:0]      r_rd_pid;
    logic                  r_rd_stale;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            mem_owner[i_waddr] <= i_wr_owner;
            mem_pid[i_waddr]   <= i_wr_pid;
            mem_stale[i_waddr] <= i_wr_stale;
        end
        if (i_cmd.rd) begin
            r_rd_owner <= mem_owner[i_raddr];
            r_rd_pid   <= mem_pid[i_raddr];
            r_rd_stale <= mem_stale[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rv    <= 1'b0;
        end else begin
            if (i_cmd.wr) begin
                r_valid[i_waddr] <= 1'b1;
            end else if (i_cmd.clr) begin
                r_valid[i_waddr] <= 1'b0;
            end
            if (i_cmd.rd) begin
                r_rv <= r_valid[i_raddr];
            end
        end
    end

    assign o_rd_owner = r_rv ? r_rd_owner : '0;
    assign o_rd_pid   = r_rv ? r_rd_pid   : '0;
    assign o_rd_stale = r_rv ? r_rd_stale : 1'b0;

endmodule

>>> hw/rtl/pat_seq.sv
// ----------------------------------------------------------------------------
// Pending ack table scan sequencer
// Walks the entries one per cycle through the store read port and applies
// the add, find-and-remove or mark-stale compare to each entry in turn.
// ----------------------------------------------------------------------------
module pat_seq #(
    parameter int ENTRIES    = pat_pkg::ENTRIES_DEF,
    parameter int OWNER_BITS = pat_pkg::OWNER_BITS_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [pat_pkg::OP_W-1:0]       i_operation,
    input  logic [pat_pkg::PID_W-1:0]      i_packet_id,
    input  logic [pat_pkg::OWNER_IO_W-1:0] i_owner_id,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output pat_pkg::t_result       o_res,
    output pat_pkg::t_store_cmd    o_cmd,
    output logic [IW-1:0]          o_raddr,
    output logic [IW-1:0]          o_waddr,
    output logic [OWNER_BITS-1:0]  o_wr_owner,
    output logic [pat_pkg::PID_W-1:0] o_wr_pid,
    output logic                   o_wr_stale,
    input  logic [OWNER_BITS-1:0]  i_rd_owner,
    input  logic [pat_pkg::PID_W-1:0] i_rd_pid,
    input  logic                   i_rd_stale
);
    import pat_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [CW-1:0]           r_ridx, n_ridx;
    logic [IW-1:0]           r_eidx, n_eidx;
    logic                    r_dv, n_dv;
    logic                    r_status, n_status;
    logic [OWNER_IO_W-1:0]   r_found, n_found;
    logic [OP_W-1:0]         r_op;
    logic [PID_W-1:0]        r_pid;
    logic [OWNER_BITS-1:0]   r_owner;

    logic                    accept;
    logic                    hit;
    logic [PID_W-1:0]        c_pid;
    logic [OWNER_BITS-1:0]   c_owner;
    logic [OWNER_BITS+OWNER_IO_W-1:0] owner_in_ext;
    logic [OWNER_BITS+OWNER_IO_W-1:0] owner_out_ext;

    assign accept  = i_valid && (r_state == S_IDLE);
    assign o_ready = (r_state == S_IDLE);

    // a stale entry reached by add or find counts as already cleared
    assign c_pid   = i_rd_stale ? '0 : i_rd_pid;
    assign c_owner = i_rd_stale ? '0 : i_rd_owner;

    assign owner_in_ext  = {{OWNER_BITS{1'b0}}, i_owner_id};
    assign owner_out_ext = {{OWNER_IO_W{1'b0}}, c_owner};

    always_comb begin
        n_state    = r_state;
        n_ridx     = r_ridx;
        n_eidx     = r_eidx;
        n_dv       = 1'b0;
        n_status   = r_status;
        n_found    = r_found;
        hit        = 1'b0;
        o_cmd      = '0;
        o_raddr    = r_ridx[IW-1:0];
        o_waddr    = r_eidx;
        o_wr_owner = r_owner;
        o_wr_pid   = r_pid;
        o_wr_stale = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_ridx = '0;
                    if (i_operation == OP_ADD || i_operation == OP_FIND ||
                        i_operation == OP_MARK) begin
                        n_state = S_SCAN;
                    end else begin
                        n_status = 1'b0;
                        n_found  = '0;
                        n_state  = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_ridx < CW'(ENTRIES)) begin
                    o_cmd.rd = 1'b1;
                    n_ridx   = r_ridx + 1'b1;
                    n_eidx   = r_ridx[IW-1:0];
                    n_dv     = 1'b1;
                end
                if (r_dv) begin
                    case (r_op)
                        OP_ADD: begin
                            if (i_rd_stale || i_rd_owner == '0) begin
                                o_cmd.wr = 1'b1;
                                hit      = 1'b1;
                                n_status = 1'b0;
                                n_found  = '0;
                            end
                        end
                        OP_FIND: begin
                            if (c_pid == r_pid) begin
                                o_cmd.clr = 1'b1;
                                hit       = 1'b1;
                                n_found   = owner_out_ext[OWNER_IO_W-1:0];
                                n_status  = (c_owner == '0);
                            end else if (i_rd_stale) begin
                                o_cmd.clr = 1'b1;
                            end
                        end
                        OP_MARK: begin
                            if (i_rd_pid == r_pid) begin
                                o_cmd.wr   = 1'b1;
                                o_wr_owner = i_rd_owner;
                                o_wr_pid   = i_rd_pid;
                                o_wr_stale = 1'b1;
                                hit        = 1'b1;
                                n_status   = 1'b0;
                                n_found    = '0;
                            end
                        end
                        default: begin
                            hit = 1'b1;
                        end
                    endcase
                    if (!hit && r_eidx == LAST_IDX) begin
                        n_status = (r_op != OP_MARK);
                        n_found  = '0;
                    end
                    if (hit || r_eidx == LAST_IDX) begin
                        n_state = S_DONE;
                        n_dv    = 1'b0;
                    end
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ridx   <= n_ridx;
        r_eidx   <= n_eidx;
        r_status <= n_status;
        r_found  <= n_found;
        if (accept) begin
            r_op    <= i_operation;
            r_pid   <= i_packet_id;
            r_owner <= owner_in_ext[OWNER_BITS-1:0];
        end
    end

    assign o_res_valid       = (r_state == S_DONE);
    assign o_res.status      = r_status;
    assign o_res.found_owner = r_found;

endmodule

>>> hw/rtl/pat_chk.sv
// ----------------------------------------------------------------------------
// Pending ack table port checker
// Checks request and result channel behavior seen at the top level ports.
// ----------------------------------------------------------------------------
module pat_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_status,
    input logic [7:0] i_found_owner
);

    // one request at a time: busy right after a transfer in
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("request taken while a scan is in progress");

    // a result only appears after the block was busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result appeared without a scan");

    // a returned owner always means success
    a_owner_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_found_owner != 8'd0) |-> (i_status == 1'b0))
        else $error("owner returned with failure status");

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_found_owner)))
        else $error("stalled result changed");

endmodule

bind pending_ack_table_top pat_chk u_pat_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_status      (o_out.status),
    .i_found_owner (o_out.found_owner)
);
